[rtl/bec_pkg.sv]
// Shared constants, types and codes of the button event coalescer.
package bec_pkg;

    localparam int QUEUE_DEPTH = 8;
    localparam int NUM_BUTTONS = 6;
    localparam int BTN_W = 3;
    localparam int NUM_WALK = (NUM_BUTTONS < 8) ? NUM_BUTTONS : 8;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam logic [BTN_W-1:0] LAST_BTN = BTN_W'(NUM_WALK - 1);

    typedef enum logic {
        OP_EDGE  = 1'b0,
        OP_FLUSH = 1'b1
    } op_kind_t;

    typedef enum logic [1:0] {
        ACT_PRESS   = 2'd0,
        ACT_RELEASE = 2'd1,
        ACT_TAP     = 2'd2,
        ACT_HELD    = 2'd3
    } act_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_EMIT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [BTN_W-1:0] btn;
        logic             prs;
    } raw_edge_t;

    typedef struct packed {
        op_kind_t  kind;
        raw_edge_t raw;
    } op_t;

endpackage

[rtl/bec_in_if.sv]
// Channel that carries raw edge and flush words into the coalescer.
interface bec_in_if;
    import bec_pkg::*;

    logic             valid;
    logic             ready;
    logic             command;
    logic [BTN_W-1:0] button_index;
    logic             pressed;

    modport source (output valid, command, button_index, pressed, input ready);
    modport sink (input valid, command, button_index, pressed, output ready);
endinterface

[rtl/bec_out_if.sv]
// Channel that carries coalesced event words out of the coalescer.
interface bec_out_if;
    import bec_pkg::*;

    logic             valid;
    logic             ready;
    logic [BTN_W-1:0] event_button;
    logic [1:0]       action;
    logic             has_event;
    logic             last;
    logic             overflowed;

    modport source (output valid, event_button, action, has_event, last, overflowed,
                    input ready);
    modport sink (input valid, event_button, action, has_event, last, overflowed,
                  output ready);
endinterface

[rtl/bec_front.sv]
// Front end: accepts input words, classifies them and buffers them in a two-entry queue.
module bec_front
    import bec_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    bec_in_if.sink  items,
    output logic    op_valid,
    input  logic    op_ready,
    output op_t     op
);

    op_t        buf_mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       push, pop;
    op_t        op_in;

    always_comb
    begin
        op_in.kind    = op_kind_t'(items.command);
        op_in.raw.btn = items.button_index;
        op_in.raw.prs = items.pressed;
    end

    assign items.ready = (fill_reg != 2'd2);
    assign op_valid    = (fill_reg != 2'd0);
    assign op          = buf_mem[rd_ptr_reg];
    assign push        = items.valid && items.ready;
    assign pop         = op_valid && op_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_mem[wr_ptr_reg] <= op_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

[rtl/bec_back.sv]
// Back end: holds the edge queue and button levels and walks the queue on a flush.
module bec_back
    import bec_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      op_valid,
    output logic      op_ready,
    input  op_t       op,
    bec_out_if.source results
);

    raw_edge_t queue_mem [QUEUE_DEPTH];
    act_t      stack_mem [QUEUE_DEPTH];

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              dropped_reg, dropped_next;
    logic [NUM_WALK-1:0] levels_reg, levels_next;
    logic [BTN_W-1:0]  btn_reg, btn_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  depth_reg, depth_next;
    logic [CNT_W-1:0]  pos_reg, pos_next;
    logic              seen_reg, seen_next;
    logic              lastp_reg, lastp_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [BTN_W-1:0]  pend_btn_reg, pend_btn_next;
    act_t              pend_act_reg, pend_act_next;
    logic              out_valid_reg, out_valid_next;
    logic [BTN_W-1:0]  out_btn_reg, out_btn_next;
    act_t              out_act_reg, out_act_next;
    logic              out_has_reg, out_has_next;
    logic              out_last_reg, out_last_next;
    logic              out_ovf_reg, out_ovf_next;

    logic              q_we;
    logic              stk_we;
    logic [IDX_W-1:0]  stk_waddr;
    act_t              stk_wdata;
    logic [IDX_W-1:0]  stk_raddr;
    act_t              top;
    raw_edge_t         cur;
    logic [CNT_W-1:0]  depth_m1;
    logic              out_free;
    logic              level_now;

    assign results.valid        = out_valid_reg;
    assign results.event_button = out_btn_reg;
    assign results.action       = out_act_reg;
    assign results.has_event    = out_has_reg;
    assign results.last         = out_last_reg;
    assign results.overflowed   = out_ovf_reg;

    assign op_ready  = (state_reg == ST_IDLE);
    assign depth_m1  = depth_reg - CNT_W'(1);
    assign cur       = queue_mem[idx_reg[IDX_W-1:0]];
    assign stk_raddr = (state_reg == ST_EMIT) ? pos_reg[IDX_W-1:0] : depth_m1[IDX_W-1:0];
    assign top       = stack_mem[stk_raddr];
    assign out_free  = !out_valid_reg || results.ready;
    assign level_now = seen_reg ? lastp_reg : levels_reg[btn_reg];

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        dropped_next    = dropped_reg;
        levels_next     = levels_reg;
        btn_next        = btn_reg;
        idx_next        = idx_reg;
        depth_next      = depth_reg;
        pos_next        = pos_reg;
        seen_next       = seen_reg;
        lastp_next      = lastp_reg;
        pend_valid_next = pend_valid_reg;
        pend_btn_next   = pend_btn_reg;
        pend_act_next   = pend_act_reg;
        out_valid_next  = out_valid_reg && !results.ready;
        out_btn_next    = out_btn_reg;
        out_act_next    = out_act_reg;
        out_has_next    = out_has_reg;
        out_last_next   = out_last_reg;
        out_ovf_next    = out_ovf_reg;
        q_we            = 1'b0;
        stk_we          = 1'b0;
        stk_waddr       = depth_reg[IDX_W-1:0];
        stk_wdata       = ACT_PRESS;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (op_valid)
                begin
                    if (op.kind == OP_FLUSH)
                    begin
                        state_next      = ST_WALK;
                        btn_next        = '0;
                        idx_next        = '0;
                        depth_next      = '0;
                        seen_next       = 1'b0;
                        pend_valid_next = 1'b0;
                    end
                    else if (count_reg < CNT_W'(QUEUE_DEPTH))
                    begin
                        q_we       = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                end
            end

            ST_WALK:
            begin
                if (idx_reg != count_reg)
                begin
                    idx_next = idx_reg + CNT_W'(1);
                    if (cur.btn == btn_reg)
                    begin
                        seen_next  = 1'b1;
                        lastp_next = cur.prs;
                        if (depth_reg == '0)
                        begin
                            stk_we     = 1'b1;
                            stk_waddr  = '0;
                            stk_wdata  = cur.prs ? ACT_PRESS : ACT_RELEASE;
                            depth_next = CNT_W'(1);
                        end
                        else if (cur.prs)
                        begin
                            if (top == ACT_RELEASE)
                            begin
                                depth_next = depth_m1;
                            end
                            else
                            begin
                                stk_we     = 1'b1;
                                stk_wdata  = ACT_PRESS;
                                depth_next = depth_reg + CNT_W'(1);
                            end
                        end
                        else
                        begin
                            if (top == ACT_PRESS)
                            begin
                                stk_we    = 1'b1;
                                stk_waddr = depth_m1[IDX_W-1:0];
                                stk_wdata = ACT_TAP;
                            end
                            else
                            begin
                                stk_we     = 1'b1;
                                stk_wdata  = ACT_RELEASE;
                                depth_next = depth_reg + CNT_W'(1);
                            end
                        end
                    end
                end
                else
                begin
                    levels_next[btn_reg] = level_now;
                    pos_next             = '0;
                    if (depth_reg != '0)
                    begin
                        state_next = ST_EMIT;
                    end
                    else if (level_now)
                    begin
                        stk_we     = 1'b1;
                        stk_waddr  = '0;
                        stk_wdata  = ACT_HELD;
                        depth_next = CNT_W'(1);
                        state_next = ST_EMIT;
                    end
                    else if (btn_reg == LAST_BTN)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        btn_next   = btn_reg + BTN_W'(1);
                        idx_next   = '0;
                        depth_next = '0;
                        seen_next  = 1'b0;
                    end
                end
            end

            ST_EMIT:
            begin
                if (!pend_valid_reg || out_free)
                begin
                    if (pend_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_btn_next   = pend_btn_reg;
                        out_act_next   = pend_act_reg;
                        out_has_next   = 1'b1;
                        out_last_next  = 1'b0;
                        out_ovf_next   = dropped_reg;
                    end
                    pend_valid_next = 1'b1;
                    pend_btn_next   = btn_reg;
                    pend_act_next   = top;
                    pos_next        = pos_reg + CNT_W'(1);
                    if (pos_reg == depth_m1)
                    begin
                        if (btn_reg == LAST_BTN)
                        begin
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            state_next = ST_WALK;
                            btn_next   = btn_reg + BTN_W'(1);
                            idx_next   = '0;
                            depth_next = '0;
                            seen_next  = 1'b0;
                        end
                    end
                end
            end

            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_btn_next    = pend_valid_reg ? pend_btn_reg : '0;
                    out_act_next    = pend_valid_reg ? pend_act_reg : ACT_PRESS;
                    out_has_next    = pend_valid_reg;
                    out_last_next   = 1'b1;
                    out_ovf_next    = dropped_reg;
                    pend_valid_next = 1'b0;
                    count_next      = '0;
                    dropped_next    = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (q_we)
        begin
            queue_mem[count_reg[IDX_W-1:0]] <= op.raw;
        end
        if (stk_we)
        begin
            stack_mem[stk_waddr] <= stk_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        btn_reg      <= btn_next;
        idx_reg      <= idx_next;
        depth_reg    <= depth_next;
        pos_reg      <= pos_next;
        seen_reg     <= seen_next;
        lastp_reg    <= lastp_next;
        pend_btn_reg <= pend_btn_next;
        pend_act_reg <= pend_act_next;
        out_btn_reg  <= out_btn_next;
        out_act_reg  <= out_act_next;
        out_has_reg  <= out_has_next;
        out_last_reg <= out_last_next;
        out_ovf_reg  <= out_ovf_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            dropped_reg    <= 1'b0;
            levels_reg     <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            dropped_reg    <= dropped_next;
            levels_reg     <= levels_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

endmodule

[rtl/button_event_coalescer.sv]
// Top level of the button event coalescer: front end, command queue and back end.
//
//   channel   direction  word
//   items     in         command, button_index, pressed
//   results   out        event_button, action, has_event, last, overflowed
//
// The back end takes a raw edge word while idle; a two-entry queue in the front
// end takes further words while the back end is busy with a flush.
// A flush is taken while the back end is idle; it then walks the queued edges once
// per button, emits each event and closes with a last word.
// Reset clears the queue count, the button levels, the drop flag and all valid flags.
// A stalled result holds an emitting back end; the front end takes up to two words.
module button_event_coalescer
    import bec_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    bec_in_if.sink     items,
    bec_out_if.source  results
);

    logic op_valid;
    logic op_ready;
    op_t  op;

    bec_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .items    (items),
        .op_valid (op_valid),
        .op_ready (op_ready),
        .op       (op)
    );

    bec_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_valid (op_valid),
        .op_ready (op_ready),
        .op       (op),
        .results  (results)
    );

endmodule

[tb/bec_checker.sv]
// Checker that predicts the coalesced event words of the block and compares them with its output.
module bec_checker
    import bec_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    bec_in_if    mon_in,
    bec_out_if   mon_out,
    output int   fail_count,
    output int   pending,
    output int   words_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [BTN_W-1:0] btn;
        act_t             act;
        logic             has;
        logic             lst;
        logic             ovf;
    } event_word_t;

    logic [BTN_W-1:0]       queued_btn [QUEUE_DEPTH];
    logic                   queued_prs [QUEUE_DEPTH];
    int                     queued_count;
    logic [NUM_BUTTONS-1:0] levels;
    logic                   dropped;
    event_word_t            expected_events [$];
    int                     mismatches;
    int                     checked;

    function automatic void push_event(logic [BTN_W-1:0] btn, act_t act, logic has);
        event_word_t w;
        w.btn = btn;
        w.act = act;
        w.has = has;
        w.lst = 1'b0;
        w.ovf = dropped;
        expected_events.push_back(w);
    endfunction

    function automatic void predict_flush();
        logic [NUM_BUTTONS-1:0] next_levels;
        act_t                   stack_acts [QUEUE_DEPTH+1];
        int                     depth;
        int                     produced;
        next_levels = levels;
        for (int i = 0; i < queued_count; i++)
        begin
            if (queued_btn[i] < NUM_BUTTONS)
            begin
                next_levels[queued_btn[i]] = queued_prs[i];
            end
        end
        produced = 0;
        for (int b = 0; b < NUM_WALK; b++)
        begin
            depth = 0;
            for (int i = 0; i < queued_count; i++)
            begin
                if (queued_btn[i] == BTN_W'(b))
                begin
                    if (depth == 0)
                    begin
                        stack_acts[0] = queued_prs[i] ? ACT_PRESS : ACT_RELEASE;
                        depth = 1;
                    end
                    else if (queued_prs[i])
                    begin
                        if (stack_acts[depth-1] == ACT_RELEASE)
                        begin
                            depth = depth - 1;
                        end
                        else
                        begin
                            stack_acts[depth] = ACT_PRESS;
                            depth = depth + 1;
                        end
                    end
                    else if (stack_acts[depth-1] == ACT_PRESS)
                    begin
                        stack_acts[depth-1] = ACT_TAP;
                    end
                    else
                    begin
                        stack_acts[depth] = ACT_RELEASE;
                        depth = depth + 1;
                    end
                end
            end
            if (depth == 0 && next_levels[b])
            begin
                push_event(BTN_W'(b), ACT_HELD, 1'b1);
                produced = produced + 1;
            end
            for (int j = 0; j < depth; j++)
            begin
                push_event(BTN_W'(b), stack_acts[j], 1'b1);
            end
            produced = produced + depth;
        end
        if (produced == 0)
        begin
            push_event('0, ACT_PRESS, 1'b0);
        end
        expected_events[expected_events.size()-1].lst = 1'b1;
        queued_count = 0;
        levels = next_levels;
        dropped = 1'b0;
    endfunction

    function automatic void check_word();
        event_word_t want;
        if (expected_events.size() == 0)
        begin
            mismatches = mismatches + 1;
            if (mismatches <= 10)
            begin
                $display("checker: unexpected word btn=%0d act=%0d has=%0b last=%0b ovf=%0b",
                         mon_out.event_button, mon_out.action, mon_out.has_event,
                         mon_out.last, mon_out.overflowed);
            end
            return;
        end
        want = expected_events.pop_front();
        checked = checked + 1;
        if (mon_out.event_button !== want.btn || mon_out.action !== want.act
            || mon_out.has_event !== want.has || mon_out.last !== want.lst
            || mon_out.overflowed !== want.ovf)
        begin
            mismatches = mismatches + 1;
            if (mismatches <= 10)
            begin
                $display("checker: mismatch expected btn=%0d act=%0d has=%0b last=%0b ovf=%0b",
                         want.btn, want.act, want.has, want.lst, want.ovf);
                $display("checker:          actual   btn=%0d act=%0d has=%0b last=%0b ovf=%0b",
                         mon_out.event_button, mon_out.action, mon_out.has_event,
                         mon_out.last, mon_out.overflowed);
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            queued_count = 0;
            levels = '0;
            dropped = 1'b0;
            expected_events.delete();
            mismatches = 0;
            checked = 0;
            fail_count <= 0;
            pending <= 0;
            words_checked <= 0;
        end
        else
        begin
            if (mon_out.valid && mon_out.ready)
            begin
                check_word();
            end
            if (mon_in.valid && mon_in.ready)
            begin
                if (mon_in.command == OP_FLUSH)
                begin
                    predict_flush();
                end
                else if (queued_count < QUEUE_DEPTH)
                begin
                    queued_btn[queued_count] = mon_in.button_index;
                    queued_prs[queued_count] = mon_in.pressed;
                    queued_count = queued_count + 1;
                end
                else
                begin
                    dropped = 1'b1;
                end
            end
            fail_count <= mismatches;
            pending <= expected_events.size();
            words_checked <= checked;
        end
    end

endmodule

[tb/tb.sv]
// Testbench top: clock, reset, stimulus, result stalls, watchdog and verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bec_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DIRECTED_WORDS = 23;
    localparam int RANDOM_WORDS = 107;

    logic       clk;
    logic       rst_n;
    int         fail_count;
    int         pending;
    int         words_checked;
    int         idle_cycles;
    int         edges_sent;
    int         flushes_sent;
    int         overflow_frames;
    logic       quiet_in;
    logic       quiet_out;
    logic [7:0] tracked_level;

    bec_in_if  items_ch ();
    bec_out_if results_ch ();

    button_event_coalescer dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items_ch),
        .results (results_ch)
    );

    bec_checker event_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .mon_in        (items_ch),
        .mon_out       (results_ch),
        .fail_count    (fail_count),
        .pending       (pending),
        .words_checked (words_checked)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (items_ch.valid && items_ch.ready)
            || (results_ch.valid && results_ch.ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: FAIL");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_word(op_kind_t kind, logic [BTN_W-1:0] btn, logic prs);
        int gap;
        gap = quiet_in ? 0 : $urandom_range(0, 16);
        repeat (gap)
        begin
            @(negedge clk);
            items_ch.valid <= 1'b0;
        end
        @(negedge clk);
        items_ch.valid <= 1'b1;
        items_ch.command <= kind;
        items_ch.button_index <= btn;
        items_ch.pressed <= prs;
        do
            @(posedge clk);
        while (items_ch.ready !== 1'b1);
        if (kind == OP_FLUSH)
        begin
            flushes_sent = flushes_sent + 1;
        end
        else
        begin
            edges_sent = edges_sent + 1;
            tracked_level[btn] = prs;
        end
    endtask

    task automatic wait_until_drained();
        @(negedge clk);
        items_ch.valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int stall;
        results_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = quiet_out ? 0 : $urandom_range(0, 16);
            repeat (stall)
            begin
                @(negedge clk);
                results_ch.ready <= 1'b0;
            end
            @(negedge clk);
            results_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (results_ch.valid !== 1'b1);
        end
    end

    initial
    begin
        int               frame_len;
        logic [BTN_W-1:0] edge_btn;
        logic             edge_prs;
        items_ch.valid = 1'b0;
        items_ch.command = OP_EDGE;
        items_ch.button_index = '0;
        items_ch.pressed = 1'b0;
        rst_n = 1'b0;
        quiet_in = 1'b0;
        quiet_out = 1'b0;
        tracked_level = '0;
        edges_sent = 0;
        flushes_sent = 0;
        overflow_frames = 1;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_word(OP_FLUSH, 3'd0, 1'b0);
        send_word(OP_EDGE, 3'd0, 1'b1);
        send_word(OP_EDGE, 3'd0, 1'b0);
        send_word(OP_FLUSH, 3'd0, 1'b0);
        send_word(OP_EDGE, 3'd5, 1'b1);
        send_word(OP_FLUSH, 3'd0, 1'b0);
        send_word(OP_FLUSH, 3'd0, 1'b0);
        send_word(OP_EDGE, 3'd5, 1'b0);
        send_word(OP_EDGE, 3'd5, 1'b1);
        send_word(OP_FLUSH, 3'd0, 1'b0);
        send_word(OP_EDGE, 3'd5, 1'b0);
        send_word(OP_FLUSH, 3'd0, 1'b0);
        send_word(OP_EDGE, 3'd1, 1'b1);
        send_word(OP_EDGE, 3'd1, 1'b0);
        send_word(OP_EDGE, 3'd1, 1'b1);
        send_word(OP_EDGE, 3'd6, 1'b1);
        send_word(OP_EDGE, 3'd7, 1'b0);
        send_word(OP_EDGE, 3'd2, 1'b1);
        send_word(OP_EDGE, 3'd3, 1'b1);
        send_word(OP_EDGE, 3'd4, 1'b1);
        send_word(OP_EDGE, 3'd4, 1'b0);
        send_word(OP_FLUSH, 3'd7, 1'b1);
        wait_until_drained();
        send_word(OP_FLUSH, 3'd0, 1'b0);
        wait_until_drained();

        while (edges_sent + flushes_sent < DIRECTED_WORDS + RANDOM_WORDS)
        begin
            quiet_in = ($urandom_range(0, 3) == 0);
            quiet_out = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 6) == 0)
            begin
                frame_len = $urandom_range(QUEUE_DEPTH + 1, QUEUE_DEPTH + 4);
                overflow_frames = overflow_frames + 1;
            end
            else
            begin
                frame_len = $urandom_range(0, QUEUE_DEPTH);
            end
            repeat (frame_len)
            begin
                if ($urandom_range(0, 7) == 0)
                begin
                    edge_btn = BTN_W'($urandom_range(0, 7));
                    edge_prs = 1'($urandom_range(0, 1));
                end
                else
                begin
                    edge_btn = BTN_W'($urandom_range(0, NUM_BUTTONS - 1));
                    edge_prs = ~tracked_level[edge_btn];
                end
                send_word(OP_EDGE, edge_btn, edge_prs);
            end
            send_word(OP_FLUSH, BTN_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
            if ($urandom_range(0, 5) == 0)
            begin
                wait_until_drained();
            end
        end

        quiet_out = 1'b0;
        wait_until_drained();
        repeat (200) @(posedge clk);
        $display("tb: sent %0d raw edge words and %0d flush words, %0d frames overflowed",
                 edges_sent, flushes_sent, overflow_frames);
        $display("tb: checked %0d coalesced event words", words_checked);
        if (fail_count == 0 && pending == 0)
        begin
            $display("tb: PASS");
        end
        else
        begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/bec_pkg.sv
rtl/bec_in_if.sv
rtl/bec_out_if.sv
rtl/bec_front.sv
rtl/bec_back.sv
rtl/button_event_coalescer.sv
tb/bec_checker.sv
tb/tb.sv
